// ===== rtl/core/sfir_pkg.sv =====
package sfir_pkg;

    // Filter geometry
    localparam int TAPS           = 50;
    localparam int NPAIR          = TAPS / 2;
    localparam int SAMPLE_W       = 16;
    localparam int COEF_FRAC_BITS = 18;

    // Datapath widths
    localparam int COEF_W = 15;              // signed, largest tap is 12689
    localparam int PRE_W  = SAMPLE_W + 1;    // sum of a mirrored pair
    localparam int PROD_W = PRE_W + COEF_W - 1;
    localparam int ACC_W  = 35;              // |sum| <= 65536 * 131070 < 2^33

    // Adder tree
    localparam int TREE_LEVELS = 5;
    localparam int TREE_LEAVES = 1 << TREE_LEVELS;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // Coefficients round(b * 2^18) for ages 0..24; age 49-i shares tap i
    localparam coef_t COEF_TAB [NPAIR] = '{
        15'sd1,     15'sd12,    15'sd47,    15'sd119,   15'sd243,
        15'sd431,   15'sd696,   15'sd1046,  15'sd1489,  15'sd2025,
        15'sd2655,  15'sd3373,  15'sd4170,  15'sd5032,  15'sd5941,
        15'sd6878,  15'sd7820,  15'sd8742,  15'sd9619,  15'sd10427,
        15'sd11141, 15'sd11740, 15'sd12207, 15'sd12527, 15'sd12689
    };

    // Per-cell control
    typedef struct packed {
        logic shift;     // a transaction is accepted: advance the delay line
        logic fill_top;  // load fill value into the forward entry
        logic fill_bot;  // load fill value into the return entry
        logic en;        // advance the arithmetic pipeline
    } cell_ctrl_t;

endpackage

// ===== rtl/core/symmetric_fir50_with_fill.sv =====
// Path: an accepted input passes the delay line, pre-add, product and adder tree registers to out_valid.
// Throughput: one transaction per cycle while in_stall is low; the folded delay line shifts once per sample
// and the multiply and adder tree stages are fully pipelined.
// A single skid entry takes one result while out_valid waits under out_stall.
// Reset (rst_n low, asynchronous) clears the delay line to zeros and all valid flags.
module symmetric_fir50_with_fill (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sfir_pkg::sample_t  sample_in,
    input  logic               cmd,
    input  sfir_pkg::sample_t  fill_value,
    output logic               out_valid,
    input  logic               out_stall,
    output sfir_pkg::sample_t  sample_out
);
    import sfir_pkg::*;

    localparam int Q_W = ACC_W - COEF_FRAC_BITS;

    // Pipeline control: freeze everything while the skid entry is occupied.
    logic pipe_en;
    logic accept;
    logic take;

    // Delay-line links between neighboring cells. The forward row runs from
    // cell 0 (newest sample) to cell NPAIR-1, turns around, and returns toward
    // cell 0, whose return entry holds the oldest sample.
    sample_t top_chain [NPAIR+1];
    sample_t bot_chain [NPAIR+1];
    prod_t   prod      [NPAIR];

    // Valid flags for history and cell stages (pre-add, product)
    logic hist_vld_reg;
    logic pre_vld_reg;
    logic prod_vld_reg;

    acc_t tree_sum;
    logic tree_vld;
    logic res_fire;

    acc_t                  rnd_sum;
    logic signed [Q_W-1:0] q_val;
    sample_t               q_sat;

    logic    out_valid_reg;
    sample_t sample_out_reg;
    logic    skid_full_reg;
    sample_t skid_reg;

    assign pipe_en  = !skid_full_reg;
    assign in_stall = skid_full_reg;
    assign accept   = in_valid && pipe_en;
    assign take     = out_valid_reg && !out_stall;

    assign top_chain[0]     = sample_in;
    assign bot_chain[NPAIR] = top_chain[NPAIR];

    for (genvar i = 0; i < NPAIR; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        assign ctrl.shift    = accept;
        assign ctrl.fill_top = cmd && (i != 0);  // newest slot always takes the sample
        assign ctrl.fill_bot = cmd;
        assign ctrl.en       = pipe_en;

        sfir_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .coef       (COEF_TAB[i]),
            .fill_value (fill_value),
            .top_in     (top_chain[i]),
            .bot_in     (bot_chain[i+1]),
            .top_out    (top_chain[i+1]),
            .bot_out    (bot_chain[i]),
            .prod       (prod[i])
        );
    end

    // Track which cell stages carry a live transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= 1'b0;
            pre_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            hist_vld_reg <= in_valid;
            pre_vld_reg  <= hist_vld_reg;
            prod_vld_reg <= pre_vld_reg;
        end
    end

    sfir_add_tree u_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (prod_vld_reg),
        .leaf      (prod),
        .sum       (tree_sum),
        .sum_valid (tree_vld)
    );

    assign res_fire = tree_vld && pipe_en;

    // Round half up, drop the fraction, then clamp to the sample range
    always_comb
    begin
        rnd_sum = tree_sum + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
        q_val   = Q_W'(rnd_sum >>> COEF_FRAC_BITS);
        if (q_val > Q_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}})))
        begin
            q_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (q_val < Q_W'(signed'({1'b1, {(SAMPLE_W-1){1'b0}}})))
        begin
            q_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            q_sat = SAMPLE_W'(q_val);
        end
    end

    // Output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (take)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (res_fire)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_full_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (take)
            begin
                sample_out_reg <= skid_reg;
            end
        end
        else if (res_fire)
        begin
            if (!out_valid_reg || take)
            begin
                sample_out_reg <= q_sat;
            end
            else
            begin
                skid_reg <= q_sat;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

`ifndef SYNTH
    // The skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid_reg)
        else $error("skid entry occupied without a pending output");

    // After a fill transaction the oldest entry carries the fill value
    a_fill_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd) |=> (bot_chain[0] == $past(fill_value)))
        else $error("fill did not reach the oldest history entry");

    // The newest entry always carries the accepted sample, fill or not
    a_newest_sample: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (top_chain[1] == $past(sample_in)))
        else $error("newest history entry lost the accepted sample");

    // Nothing leaves the tree while the pipeline is frozen
    a_frozen_tree: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |=> $stable(tree_sum) || !$past(skid_full_reg))
        else $error("adder tree moved while the pipeline was frozen");
`endif

endmodule

// ===== rtl/core/sfir_cell.sv =====
module sfir_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sfir_pkg::cell_ctrl_t ctrl,
    input  sfir_pkg::coef_t     coef,
    input  sfir_pkg::sample_t   fill_value,
    input  sfir_pkg::sample_t   top_in,
    input  sfir_pkg::sample_t   bot_in,
    output sfir_pkg::sample_t   top_out,
    output sfir_pkg::sample_t   bot_out,
    output sfir_pkg::prod_t     prod
);
    import sfir_pkg::*;

    sample_t                   top_reg, top_next;
    sample_t                   bot_reg, bot_next;
    logic signed [PRE_W-1:0]   pre_reg;
    prod_t                     prod_reg;

    // Forward entry holds age i, return entry holds age TAPS-1-i
    always_comb
    begin
        top_next = top_reg;
        bot_next = bot_reg;
        if (ctrl.shift)
        begin
            top_next = ctrl.fill_top ? fill_value : top_in;
            bot_next = ctrl.fill_bot ? fill_value : bot_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            bot_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
        end
    end

    // Pre-add the mirrored pair, then weight it
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            pre_reg  <= PRE_W'(top_reg) + PRE_W'(bot_reg);
            prod_reg <= PROD_W'(pre_reg * PROD_W'(coef));
        end
    end

    assign top_out = top_reg;
    assign bot_out = bot_reg;
    assign prod    = prod_reg;

endmodule

// ===== rtl/core/sfir_add_tree.sv =====
module sfir_add_tree (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  sfir_pkg::prod_t  leaf [sfir_pkg::NPAIR],
    output sfir_pkg::acc_t   sum,
    output logic             sum_valid
);
    import sfir_pkg::*;

    // Heap order: node k adds nodes 2k and 2k+1; indexes from TREE_LEAVES up are leaves
    acc_t                   node_reg [1:TREE_LEAVES-1];
    logic [TREE_LEVELS-1:0] vld_reg;

    for (genvar k = 1; k < TREE_LEAVES; k++)
    begin : g_node
        acc_t lhs;
        acc_t rhs;
        if (k >= TREE_LEAVES / 2)
        begin : g_leaf
            localparam int LI = 2 * k - TREE_LEAVES;
            if (LI < NPAIR)
            begin : g_l
                assign lhs = ACC_W'(leaf[LI]);
            end
            else
            begin : g_lz
                assign lhs = '0;
            end
            if (LI + 1 < NPAIR)
            begin : g_r
                assign rhs = ACC_W'(leaf[LI + 1]);
            end
            else
            begin : g_rz
                assign rhs = '0;
            end
        end
        else
        begin : g_inner
            assign lhs = node_reg[2 * k];
            assign rhs = node_reg[2 * k + 1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                node_reg[k] <= lhs + rhs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TREE_LEVELS-2:0], in_valid};
        end
    end

    assign sum       = node_reg[1];
    assign sum_valid = vld_reg[TREE_LEVELS-1];

endmodule
